>>> sv/vpa_pkg.sv
// Types and constants shared by the variable partition allocator.
// No dependencies.
`default_nettype none
package vpa_pkg;
    // address width of holes and job blocks, fixed by the 16-bit ports
    localparam int ADDR_BITS = 16;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_FIT    = 3'd1;
    localparam logic [2:0] ST_ID_USED   = 3'd2;
    localparam logic [2:0] ST_UNKNOWN   = 3'd3;
    localparam logic [2:0] ST_TABLE_FULL = 3'd4;

    localparam logic [1:0] REG_FIT_POLICY = 2'd0;
    localparam logic [1:0] REG_MIN_REM    = 2'd1;
    localparam logic [1:0] REG_MEM_SIZE   = 2'd2;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_NEXT  = 2'd1;
    localparam logic [1:0] FIT_BEST  = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [15:0] MIN_REM_RESET  = 16'd4;
    localparam logic [15:0] MEM_SIZE_RESET = 16'hFFFF;

    // controller -> datapath
    typedef struct packed {
        logic init;       // rebuild the table from memory_size
        logic load;       // capture the request word
        logic scan_start; // reset the scan index
        logic scan_step;  // examine hole at scan index, advance
        logic do_alloc;   // commit the chosen hole
        logic free_eval;  // latch neighbour flags at scan index
        logic free_merge; // apply the merge into the neighbouring holes
        logic shift_step; // one entry of a shift
        logic free_done;  // finish a free (insert or close up)
    } vpa_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_free;
        logic id_bad;
        logic id_valid;
        logic scan_last;   // scan index reached its end
        logic scan_stop;   // first/next fit found a hole
        logic have_hole;
        logic pos_found;   // free position search finished
        logic shift_left;  // free needs a left shift (both neighbours)
        logic shift_right; // free needs a right shift (insert)
        logic no_shift;    // merge or nothing to do
        logic full;
        logic shift_last;
    } vpa_sts_t;
endpackage
`default_nettype wire

>>> sv/variable_partition_allocator.sv
// Variable partition allocator: 16-entry address-ordered hole table.
// Allocate walks the hole table by scan index; free searches the position and, when the
// table must shift, shifts it one entry per cycle; one request at a time.
// Reset (synchronous, aresetn low): one hole [0, 65535), no jobs, first fit.
// A memory_size write rebuilds the table from the written size.
`default_nettype none
module variable_partition_allocator #(
    parameter int HOLE_ENTRIES = 16,
    parameter int JOB_SLOTS    = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_mode,
    input  wire logic [3:0]  s_job_id,
    input  wire logic [15:0] s_req_size,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [15:0]      m_block_start,
    output logic [15:0]      m_block_len
);
    logic [1:0]  fit_reg;
    logic [15:0] minr_reg;
    logic        cfg_we, cfg_init;
    logic        res_load, req_free;
    logic [2:0]  res_status;
    logic [15:0] res_start, res_size;
    logic        ctl_valid;
    logic        m_valid_block;
    vpa_pkg::vpa_cmd_t cmd;
    vpa_pkg::vpa_sts_t sts;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign cfg_init  = cfg_we && (cfg_index == vpa_pkg::REG_MEM_SIZE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_reg   <= vpa_pkg::FIT_FIRST;
            minr_reg  <= vpa_pkg::MIN_REM_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                vpa_pkg::REG_FIT_POLICY: fit_reg   <= (cfg_data[1:0] == 2'd3) ?
                                                      vpa_pkg::FIT_FIRST : cfg_data[1:0];
                vpa_pkg::REG_MIN_REM:    minr_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    vpa_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid && !m_valid_block),
        .s_ready(ctl_valid), .res_load(res_load), .res_free(req_free),
        .cfg_init(cfg_init), .cmd(cmd), .sts(sts), .res_status(res_status)
    );

    // no new word while the output register holds a result that is not being taken
    assign m_valid_block = m_valid && !m_ready;
    assign s_ready = ctl_valid && !m_valid_block;

    vpa_dp #(
        .HOLE_ENTRIES(HOLE_ENTRIES), .JOB_SLOTS(JOB_SLOTS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .fit_policy(fit_reg), .min_remainder(minr_reg), .memory_size(cfg_data),
        .s_mode(s_mode), .s_job_id(s_job_id), .s_req_size(s_req_size),
        .req_free(req_free), .res_start(res_start), .res_size(res_size)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (res_load) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_status      <= res_status;
            m_block_start <= res_start;
            m_block_len   <= res_size;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result word dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> !(m_valid && !m_ready))
        else $error("result overwritten");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !m_valid_block)
        else $error("word taken while output stalled");
endmodule
`default_nettype wire

>>> sv/vpa_ctrl.sv
// Request sequencer of the allocator.
// Depends on vpa_pkg.
`default_nettype none
module vpa_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output logic                  res_load,
    input  wire logic             res_free,
    input  wire logic             cfg_init,
    output vpa_pkg::vpa_cmd_t     cmd,
    input  wire vpa_pkg::vpa_sts_t sts,
    output logic [2:0]            res_status
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_FPOS  = 7'b0001000,
        S_FEVAL = 7'b0010000,
        S_SHIFT = 7'b0100000,
        S_WAIT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] status_reg, status_next;

    assign s_ready    = (state_reg == S_IDLE) && !cfg_init;
    assign res_status = status_reg;

    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        res_load    = 1'b0;
        cmd.init    = cfg_init;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.scan_start = 1'b1;
                if (sts.id_bad) begin
                    status_next = vpa_pkg::ST_UNKNOWN;
                    state_next  = S_WAIT;
                end else if (!sts.is_free && sts.id_valid) begin
                    status_next = vpa_pkg::ST_ID_USED;
                    state_next  = S_WAIT;
                end else if (sts.is_free && !sts.id_valid) begin
                    status_next = vpa_pkg::ST_UNKNOWN;
                    state_next  = S_WAIT;
                end else if (sts.is_free) begin
                    state_next = S_FPOS;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (sts.scan_stop || sts.scan_last) begin
                    if (sts.have_hole || sts.scan_stop) begin
                        cmd.do_alloc = 1'b1;
                        status_next  = vpa_pkg::ST_OK;
                    end else begin
                        status_next = vpa_pkg::ST_NO_FIT;
                    end
                    state_next = S_WAIT;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_FPOS: begin
                if (sts.pos_found) begin
                    cmd.free_eval = 1'b1;
                    state_next    = S_FEVAL;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_FEVAL: begin
                status_next = vpa_pkg::ST_OK;
                if (sts.no_shift) begin
                    cmd.free_merge = 1'b1;
                    cmd.free_done  = 1'b1;
                    state_next     = S_WAIT;
                end else if (sts.shift_right && sts.full) begin
                    status_next = vpa_pkg::ST_TABLE_FULL;
                    state_next  = S_WAIT;
                end else begin
                    cmd.free_merge = 1'b1;
                    state_next     = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (sts.shift_last) begin
                    cmd.free_done = 1'b1;
                    state_next    = S_WAIT;
                end else begin
                    cmd.shift_step = 1'b1;
                end
            end
            S_WAIT: begin
                res_load   = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= vpa_pkg::ST_OK;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT) |-> res_free)
        else $error("shift outside free");
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |=> (state_reg == S_IDLE))
        else $error("result load not followed by idle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_ready && s_valid) |=> (state_reg == S_CHECK))
        else $error("accepted word not checked");
endmodule
`default_nettype wire

>>> sv/vpa_dp.sv
// Hole table, job table and scan datapath of the allocator.
// Depends on vpa_pkg.
`default_nettype none
module vpa_dp #(
    parameter int HOLE_ENTRIES = 16,
    parameter int JOB_SLOTS    = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire vpa_pkg::vpa_cmd_t      cmd,
    output vpa_pkg::vpa_sts_t           sts,
    input  wire logic [1:0]             fit_policy,
    input  wire logic [15:0]            min_remainder,
    input  wire logic [15:0]            memory_size,
    input  wire logic                   s_mode,
    input  wire logic [3:0]             s_job_id,
    input  wire logic [15:0]            s_req_size,
    output logic                        req_free,
    output logic [15:0]                 res_start,
    output logic [15:0]                 res_size
);
    localparam int HW = $clog2(HOLE_ENTRIES);
    localparam int CW = $clog2(HOLE_ENTRIES + 1);
    localparam int JW = $clog2(JOB_SLOTS);
    localparam int AW = vpa_pkg::ADDR_BITS;

    logic [AW-1:0] hs_reg [HOLE_ENTRIES];
    logic [AW-1:0] hz_reg [HOLE_ENTRIES];
    logic [CW-1:0] cnt_reg;
    logic [HW-1:0] rover_reg;
    logic [JOB_SLOTS-1:0] jv_reg;
    logic [AW-1:0] js_mem [JOB_SLOTS];
    logic [AW-1:0] jl_mem [JOB_SLOTS];

    logic          mode_reg;
    logic [3:0]    id_reg;
    logic [15:0]   req_reg;
    logic [CW-1:0] idx_reg;      // scan step count / free position
    logic [HW-1:0] hp_reg;       // hole pointer for next fit
    logic [HW-1:0] best_reg;
    logic          have_reg;
    logic          below_reg, above_reg;
    logic [AW-1:0] fs_reg, fl_reg;
    logic [CW-1:0] sh_reg;       // shift pointer
    logic [15:0]   out_s_reg, out_z_reg;

    logic          id_bad;
    logic [JW-1:0] jidx;
    logic [HW-1:0] cur;
    logic [AW:0]   need;
    logic          fit_ok;
    logic [AW-1:0] cur_z, cur_s;
    logic [AW:0]   bend;
    logic [AW:0]   send;
    logic          zero_len;

    assign id_bad = ({28'd0, id_reg} >= JOB_SLOTS);
    assign jidx   = JW'(id_reg);
    assign cur    = (fit_policy == vpa_pkg::FIT_NEXT) ? hp_reg : HW'(idx_reg);
    assign cur_z  = hz_reg[cur];
    assign cur_s  = hs_reg[cur];
    assign need   = {1'b0, AW'(req_reg)} + {1'b0, AW'(min_remainder)};
    assign fit_ok = {1'b0, cur_z} > need;
    assign zero_len = (fl_reg == '0);

    // neighbour below is entry idx-1, above is entry idx
    logic [HW-1:0] pm1;
    assign pm1  = HW'(idx_reg - CW'(1));
    assign bend = {1'b0, hs_reg[pm1]} + {1'b0, hz_reg[pm1]};
    assign send = {1'b0, fs_reg} + {1'b0, fl_reg};

    always_comb begin
        sts          = '0;
        sts.is_free  = mode_reg;
        sts.id_bad   = id_bad;
        sts.id_valid = jv_reg[jidx];
        sts.scan_last = (idx_reg >= cnt_reg);
        sts.scan_stop = (idx_reg < cnt_reg) && fit_ok
                        && (fit_policy != vpa_pkg::FIT_BEST);
        sts.have_hole = have_reg;
        sts.pos_found = (idx_reg >= cnt_reg) || (hs_reg[HW'(idx_reg)] > fs_reg);
        sts.no_shift  = zero_len || (below_reg != above_reg);
        sts.shift_left  = !zero_len && below_reg && above_reg;
        sts.shift_right = !zero_len && !below_reg && !above_reg;
        sts.full      = (cnt_reg >= CW'(HOLE_ENTRIES));
        sts.shift_last = below_reg ? (sh_reg + CW'(1) >= cnt_reg) : (sh_reg <= idx_reg);
    end

    assign req_free  = mode_reg;
    assign res_start = out_s_reg;
    assign res_size  = out_z_reg;

    logic [HW-1:0] chosen;
    assign chosen = (fit_policy == vpa_pkg::FIT_BEST) ? best_reg : cur;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= s_mode;
            id_reg   <= s_job_id;
            req_reg  <= s_req_size;
        end
        if (cmd.scan_start) begin
            idx_reg   <= '0;
            hp_reg    <= ({1'b0, rover_reg} < cnt_reg) ? rover_reg : '0;
            have_reg  <= 1'b0;
            out_s_reg <= '0;
            out_z_reg <= '0;
            fs_reg    <= js_mem[jidx];
            fl_reg    <= jl_mem[jidx];
        end
        if (cmd.scan_step) begin
            idx_reg <= idx_reg + CW'(1);
            hp_reg  <= ({1'b0, hp_reg} + CW'(1) >= cnt_reg) ? '0 : hp_reg + HW'(1);
            if (!mode_reg && fit_ok && (!have_reg || cur_z < hz_reg[best_reg])) begin
                best_reg <= cur;
                have_reg <= 1'b1;
            end
        end
        if (cmd.do_alloc) begin
            out_s_reg <= 16'(hs_reg[chosen]);
            out_z_reg <= req_reg;
        end
        if (cmd.free_eval) begin
            below_reg <= (idx_reg != '0) && (bend == {1'b0, fs_reg});
            above_reg <= (idx_reg < cnt_reg) && (send == {1'b0, hs_reg[HW'(idx_reg)]});
        end
        if (cmd.free_done) begin
            out_s_reg <= 16'(fs_reg);
            out_z_reg <= 16'(fl_reg);
        end
        if (cmd.free_eval && !((idx_reg != '0) && (bend == {1'b0, fs_reg}))) begin
            sh_reg <= cnt_reg;
        end else if (cmd.free_eval) begin
            sh_reg <= idx_reg;
        end
        if (cmd.shift_step) begin
            sh_reg <= below_reg ? sh_reg + CW'(1) : sh_reg - CW'(1);
        end
        if (cmd.do_alloc) begin
            js_mem[jidx] <= hs_reg[chosen];
            jl_mem[jidx] <= AW'(req_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.init) begin
            for (int i = 0; i < HOLE_ENTRIES; i++) begin
                hs_reg[i] <= '0;
                hz_reg[i] <= (i == 0) ?
                             AW'(!aresetn ? vpa_pkg::MEM_SIZE_RESET : memory_size) : '0;
            end
            cnt_reg   <= CW'(1);
            rover_reg <= '0;
            jv_reg    <= '0;
        end else begin
            if (cmd.do_alloc) begin
                hs_reg[chosen] <= hs_reg[chosen] + AW'(req_reg);
                hz_reg[chosen] <= hz_reg[chosen] - AW'(req_reg);
                jv_reg[jidx]   <= 1'b1;
                rover_reg      <= chosen;
            end
            if (cmd.free_merge && !zero_len) begin
                if (below_reg && above_reg) begin
                    hz_reg[pm1] <= hz_reg[pm1] + fl_reg + hz_reg[HW'(idx_reg)];
                end else if (below_reg) begin
                    hz_reg[pm1] <= hz_reg[pm1] + fl_reg;
                end else if (above_reg) begin
                    hs_reg[HW'(idx_reg)] <= fs_reg;
                    hz_reg[HW'(idx_reg)] <= hz_reg[HW'(idx_reg)] + fl_reg;
                end
            end
            if (cmd.shift_step) begin
                if (below_reg) begin
                    hs_reg[HW'(sh_reg)] <= hs_reg[HW'(sh_reg + CW'(1))];
                    hz_reg[HW'(sh_reg)] <= hz_reg[HW'(sh_reg + CW'(1))];
                end else begin
                    hs_reg[HW'(sh_reg)] <= hs_reg[HW'(sh_reg - CW'(1))];
                    hz_reg[HW'(sh_reg)] <= hz_reg[HW'(sh_reg - CW'(1))];
                end
            end
            if (cmd.free_done) begin
                jv_reg[jidx] <= 1'b0;
                if (!zero_len && below_reg && above_reg) begin
                    cnt_reg <= cnt_reg - CW'(1);
                end else if (!zero_len && !below_reg && !above_reg) begin
                    hs_reg[HW'(idx_reg)] <= fs_reg;
                    hz_reg[HW'(idx_reg)] <= fl_reg;
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != '0) && (cnt_reg <= CW'(HOLE_ENTRIES)))
        else $error("hole count out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_alloc |-> !jv_reg[jidx])
        else $error("allocate over a live job");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.free_done |-> jv_reg[jidx])
        else $error("free of a dead job");
endmodule
`default_nettype wire
